// File: src/assert_macros.svh
// Assertion macros shared by the tokenizer modules.
// No dependencies; included by each module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SCT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define SCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/sct_pkg.sv
// Types, token codes, character constants and classifier functions of the tokenizer.
// No dependencies; imported by every tokenizer module.
package sct_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned KIND_W      = 6;
  localparam int unsigned TDATA_W     = 56;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [KIND_W-1:0]      tkind_t;

  localparam field_t LINE_MAX = '1;

  localparam tkind_t TK_LEFT_PAREN    = 6'd0;
  localparam tkind_t TK_RIGHT_PAREN   = 6'd1;
  localparam tkind_t TK_LEFT_BRACE    = 6'd2;
  localparam tkind_t TK_RIGHT_BRACE   = 6'd3;
  localparam tkind_t TK_LEFT_BRACKET  = 6'd4;
  localparam tkind_t TK_RIGHT_BRACKET = 6'd5;
  localparam tkind_t TK_COMMA         = 6'd6;
  localparam tkind_t TK_DOT           = 6'd7;
  localparam tkind_t TK_MINUS         = 6'd8;
  localparam tkind_t TK_PLUS          = 6'd9;
  localparam tkind_t TK_SEMICOLON     = 6'd10;
  localparam tkind_t TK_STAR          = 6'd11;
  localparam tkind_t TK_BANG_EQUAL    = 6'd12;
  localparam tkind_t TK_SLASH         = 6'd24;
  localparam tkind_t TK_NEWLINE       = 6'd25;
  localparam tkind_t TK_STRING        = 6'd26;
  localparam tkind_t TK_DECORATOR     = 6'd27;
  localparam tkind_t TK_NUMBER        = 6'd28;
  localparam tkind_t TK_IDENTIFIER    = 6'd29;
  localparam tkind_t TK_END_OF_FILE   = 6'd30;
  localparam tkind_t TK_ERR_CHAR      = 6'd31;
  localparam tkind_t TK_ERR_STRING    = 6'd32;
  localparam tkind_t TK_ERR_NUMBER    = 6'd33;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_QUESTION   = 8'h3F;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [3:0] {
    SM_IDLE,
    SM_OP_BANG,
    SM_OP_EQUAL,
    SM_OP_LESS,
    SM_OP_GREATER,
    SM_OP_COLON,
    SM_OP_QUESTION,
    SM_STRING,
    SM_NUMBER,
    SM_IDENT
  } scan_mode_e;

  typedef struct packed {
    tkind_t kind;
    field_t start;
    field_t length;
    field_t line;
    logic   last;
  } sct_token_t;

  typedef struct packed {
    logic [1:0] count;
    sct_token_t tok0;
    sct_token_t tok1;
  } sct_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE};
  endfunction

  // {hit, kind} for one-byte tokens
  function automatic logic [KIND_W:0] single_kind(input logic [7:0] c);
    logic [KIND_W:0] r;
    case (c)
      8'h28:   r = {1'b1, TK_LEFT_PAREN};
      8'h29:   r = {1'b1, TK_RIGHT_PAREN};
      8'h7B:   r = {1'b1, TK_LEFT_BRACE};
      8'h7D:   r = {1'b1, TK_RIGHT_BRACE};
      8'h5B:   r = {1'b1, TK_LEFT_BRACKET};
      8'h5D:   r = {1'b1, TK_RIGHT_BRACKET};
      8'h2C:   r = {1'b1, TK_COMMA};
      CH_DOT:  r = {1'b1, TK_DOT};
      8'h2D:   r = {1'b1, TK_MINUS};
      8'h2B:   r = {1'b1, TK_PLUS};
      8'h3B:   r = {1'b1, TK_SEMICOLON};
      8'h2A:   r = {1'b1, TK_STAR};
      8'h2F:   r = {1'b1, TK_SLASH};
      CH_AT:   r = {1'b1, TK_DECORATOR};
      default: r = '0;
    endcase
    return r;
  endfunction

  // {hit, index} for bytes that may open a two-byte operator
  function automatic logic [3:0] op_index(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      CH_BANG:     r = {1'b1, 3'd0};
      CH_EQUAL:    r = {1'b1, 3'd1};
      CH_LESS:     r = {1'b1, 3'd2};
      CH_GREATER:  r = {1'b1, 3'd3};
      CH_COLON:    r = {1'b1, 3'd4};
      CH_QUESTION: r = {1'b1, 3'd5};
      default:     r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd4:    r = CH_COLON;
      3'd5:    r = CH_QUESTION;
      default: r = CH_EQUAL;
    endcase
    return r;
  endfunction

  function automatic sct_token_t mk_tok(input tkind_t kind, input offset_t start,
                                        input offset_t length, input field_t line);
    sct_token_t t;
    t.kind   = kind;
    t.start  = FIELD_W'(start);
    t.length = FIELD_W'(length);
    t.line   = line;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

// File: src/sct_scanner.sv
// Scanner state and single-pass token classification of one source byte.
// Depends on sct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sct_scanner import sct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        kind_i,
  input  logic [7:0]  char_i,
  output sct_result_t res_o
);

  scan_mode_e mode_q, mode_d;
  offset_t    pos_q, pos_d;
  offset_t    start_q, start_d;
  field_t     line_q, line_d;
  logic       dot_q, dot_d;
  logic       fin_q, fin_d;

  logic            at_end;
  offset_t         span;
  field_t          line_inc;
  logic [2:0]      cur_op;
  logic            consumed;
  logic            p_hit, f_hit;
  sct_token_t      p_tok, f_tok;
  logic [KIND_W:0] sk;
  logic [3:0]      oi;

  always_comb begin
    at_end   = kind_i | (char_i == CH_NUL);
    span     = pos_q - start_q;
    line_inc = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
    cur_op   = 3'(4'(mode_q) - 4'(SM_OP_BANG));
    sk       = single_kind(char_i);
    oi       = op_index(char_i);
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    line_d   = line_q;
    dot_d    = dot_q;
    fin_d    = fin_q;
    consumed = 1'b0;
    p_hit    = 1'b0;
    f_hit    = 1'b0;
    p_tok    = mk_tok(TK_END_OF_FILE, pos_q, '0, line_q);
    f_tok    = p_tok;
    if (fin_q) begin
      // hold everything until reset
    end else if (at_end) begin
      p_hit = 1'b1;
      case (mode_q)
        SM_OP_BANG, SM_OP_EQUAL, SM_OP_LESS, SM_OP_GREATER, SM_OP_COLON,
        SM_OP_QUESTION: begin
          p_tok = mk_tok(TK_BANG_EQUAL + {2'b0, cur_op, 1'b1}, start_q,
                         OFFSET_BITS'(1), line_q);
        end
        SM_STRING: p_tok = mk_tok(TK_ERR_STRING, start_q, span, line_q);
        SM_NUMBER: p_tok = mk_tok(TK_NUMBER, start_q, span, line_q);
        SM_IDENT:  p_tok = mk_tok(TK_IDENTIFIER, start_q, span, line_q);
        default:   p_hit = 1'b0;
      endcase
      f_hit  = 1'b1;
      f_tok  = mk_tok(TK_END_OF_FILE, pos_q, '0, line_q);
      mode_d = SM_IDLE;
      fin_d  = 1'b1;
    end else begin
      case (mode_q)
        SM_OP_BANG, SM_OP_EQUAL, SM_OP_LESS, SM_OP_GREATER, SM_OP_COLON,
        SM_OP_QUESTION: begin
          p_hit = 1'b1;
          if (char_i == op_second(cur_op)) begin
            consumed = 1'b1;
            p_tok = mk_tok(TK_BANG_EQUAL + {2'b0, cur_op, 1'b0}, start_q,
                           OFFSET_BITS'(2), line_q);
          end else begin
            p_tok = mk_tok(TK_BANG_EQUAL + {2'b0, cur_op, 1'b1}, start_q,
                           OFFSET_BITS'(1), line_q);
          end
          mode_d = SM_IDLE;
        end
        SM_STRING: begin
          consumed = 1'b1;
          if (char_i == CH_QUOTE) begin
            p_hit  = 1'b1;
            p_tok  = mk_tok(TK_STRING, start_q, span, line_q);
            mode_d = SM_IDLE;
          end else if (char_i == CH_LF) begin
            line_d = line_inc;
          end
        end
        SM_NUMBER: begin
          if (is_digit(char_i)) begin
            consumed = 1'b1;
          end else if (char_i == CH_DOT) begin
            consumed = 1'b1;
            if (dot_q) begin
              p_hit  = 1'b1;
              p_tok  = mk_tok(TK_ERR_NUMBER, start_q, span + 1'b1, line_q);
              mode_d = SM_IDLE;
            end else begin
              dot_d = 1'b1;
            end
          end else begin
            p_hit  = 1'b1;
            p_tok  = mk_tok(TK_NUMBER, start_q, span, line_q);
            mode_d = SM_IDLE;
          end
        end
        SM_IDENT: begin
          if (is_alpha(char_i) || is_digit(char_i)) begin
            consumed = 1'b1;
          end else begin
            p_hit  = 1'b1;
            p_tok  = mk_tok(TK_IDENTIFIER, start_q, span, line_q);
            mode_d = SM_IDLE;
          end
        end
        default: mode_d = SM_IDLE;
      endcase
      if (!consumed) begin
        if (sk[KIND_W]) begin
          f_hit = 1'b1;
          f_tok = mk_tok(sk[KIND_W-1:0], pos_q, OFFSET_BITS'(1), line_q);
        end else if (oi[3]) begin
          mode_d  = scan_mode_e'(4'(SM_OP_BANG) + {1'b0, oi[2:0]});
          start_d = pos_q;
        end else if (char_i == CH_SPACE || char_i == CH_CR || char_i == CH_TAB) begin
          // skip blanks
        end else if (char_i == CH_LF) begin
          line_d = line_inc;
          f_hit  = 1'b1;
          f_tok  = mk_tok(TK_NEWLINE, pos_q, OFFSET_BITS'(1), line_inc);
        end else if (char_i == CH_QUOTE) begin
          mode_d  = SM_STRING;
          start_d = pos_q + 1'b1;
        end else if (is_digit(char_i)) begin
          mode_d  = SM_NUMBER;
          start_d = pos_q;
          dot_d   = 1'b0;
        end else if (is_alpha(char_i)) begin
          mode_d  = SM_IDENT;
          start_d = pos_q;
        end else begin
          f_hit = 1'b1;
          f_tok = mk_tok(TK_ERR_CHAR, pos_q, OFFSET_BITS'(1), line_q);
        end
      end
      pos_d = pos_q + 1'b1;
    end
  end

  always_comb begin
    res_o.count     = 2'({1'b0, p_hit} + {1'b0, f_hit});
    res_o.tok0      = p_hit ? p_tok : f_tok;
    res_o.tok0.last = !(p_hit && f_hit);
    res_o.tok1      = f_tok;
    res_o.tok1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= SM_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      line_q  <= FIELD_W'(1);
      dot_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      line_q  <= line_d;
      dot_q   <= dot_d;
      fin_q   <= fin_d;
    end
  end

  `SCT_ASSERT_ALWAYS(a_line_nonzero, clk_i, rst_ni, line_q != '0)
  `SCT_ASSERT_NEXT(a_fin_sticky, clk_i, rst_ni, fin_q, fin_q && $stable(pos_q))
  `SCT_ASSERT_SAME(a_fin_silent, clk_i, rst_ni, fin_q, res_o.count == 2'd0)
  `SCT_ASSERT_SAME(a_end_emits, clk_i, rst_ni, !fin_q && at_end,
                   res_o.count != 2'd0 && res_o.tok1.kind == TK_END_OF_FILE)

endmodule

// File: src/sct_out_buf.sv
// Two-entry result register that serialises up to two tokens per item onto the output.
// Depends on sct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sct_out_buf import sct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sct_result_t res_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        take_i,
  output sct_token_t  head_o
);

  logic [1:0] cnt_q, cnt_d;
  sct_token_t slot0_q, slot1_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot0_q;
  assign pop     = valid_o && take_i;
  assign ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take_i);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i) begin
      cnt_d = res_i.count;
    end else if (pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot0_q <= res_i.tok0;
      slot1_q <= res_i.tok1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  `SCT_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3)
  `SCT_ASSERT_SAME(a_push_room, clk_i, rst_ni, push_i, ready_o)
  `SCT_ASSERT_NEXT(a_pair_held, clk_i, rst_ni, push_i && res_i.count == 2'd2,
                   cnt_q == 2'd2 && !head_o.last)

endmodule

// File: src/source_char_tokenizer.sv
// Streaming source tokenizer: one source byte per item in, zero, one or two tokens per item out.
// An accepted byte passes the input register and then the result register before its first token reaches the output.
// Throughput: 1 item per cycle while the output takes each token; an item that yields two
// tokens stalls the next item until the two-entry result register has drained its first token.
// Reset: asynchronous, active low; clears scanner state (line count to 1), no clearing pass.
// Depends on sct_pkg, sct_scanner and sct_out_buf.
module source_char_tokenizer import sct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [7:0] char_byte
  input  logic               s_axis_tuser,  // [0] kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // token_kind, start_offset, token_length,
                                            // line_number, zero pad
  output logic               m_axis_tlast
);

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_kind_q;
  logic        buf_ready;
  logic        step;
  sct_result_t res;
  sct_token_t  head;

  assign step          = in_valid_q && buf_ready;
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_kind_q <= s_axis_tuser;
    end
  end

  sct_scanner u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .kind_i (in_kind_q),
    .char_i (in_char_q),
    .res_o  (res)
  );

  sct_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .res_i   (res),
    .ready_o (buf_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {2'b00, head.line, head.length, head.start, head.kind};
  assign m_axis_tlast = head.last;

endmodule
